// File: rtl/brbf_pkg.sv
// brbf_pkg: shared types, constants and index arithmetic for the byte ring buffer fifo
// no dependencies; used by byte_ring_buffer_fifo and brbf_checker
`timescale 1ns / 1ps

package brbf_pkg;

  // storage depth and derived widths
  localparam int DEPTH  = 1024;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = 11;
  localparam int DATA_W = 8;
  localparam int OFF_W  = 10;
  localparam int KIND_W = 3;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 3'd0,
    KIND_READ  = 3'd1,
    KIND_PEEK  = 3'd2,
    KIND_POP   = 3'd3,
    KIND_CLEAR = 3'd4
  } kind_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] write_data;
    logic [OFF_W-1:0]  peek_offset;
    logic [CNT_W-1:0]  pop_count;
  } brbf_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              done_res;
    logic [CNT_W-1:0]  count_done;
    logic [CNT_W-1:0]  fill_level;
    logic [CNT_W-1:0]  free_level;
  } brbf_out_t;

  // effective capacity: zero acts as one, above depth acts as depth
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = c;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (c > DEPTH_CNT) begin
      r = DEPTH_CNT;
    end
    return r;
  endfunction

  // index advance with wrap; a < cap and n <= cap so one subtract is enough
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [CNT_W-1:0] n,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(a) + (CNT_W+1)'(n);
    if (s >= (CNT_W+1)'(cap)) begin
      s = s - (CNT_W+1)'(cap);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

// File: rtl/brbf_ram.sv
// brbf_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module brbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/byte_ring_buffer_fifo.sv
// byte_ring_buffer_fifo: top level of the byte circular fifo with programmable capacity
// depends on brbf_pkg and brbf_ram
`timescale 1ns / 1ps

// One operation item (write, read, peek, pop or clear) is taken per clock while
// req_stall is low, and each gives exactly one result item via the ram read stage
// (registered read port of the 1024 x 8 storage ram) and result register. The
// operation is decoded and the read/write indices and fill count are updated
// in the accept cycle, so back-to-back items see each other's effect. A
// two-entry path (ram read stage plus result register) lets a new item enter
// while a finished result waits; req_stall rises only when both are full and
// rsp_stall is high. Storage is never cleared: the fill count keeps reads
// inside written bytes, so there is no clearing pass after reset. Writing
// cfg_data (capacity, 0 acts as 1, above 1024 acts as 1024) empties the
// buffer and must only be done while no item is in flight.
module byte_ring_buffer_fifo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [brbf_pkg::CNT_W-1:0] cfg_data,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  brbf_pkg::brbf_in_t        req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output brbf_pkg::brbf_out_t       rsp
);

  // control state
  logic [brbf_pkg::CNT_W-1:0] capacity;
  logic [brbf_pkg::IDX_W-1:0] read_index, read_index_next;
  logic [brbf_pkg::IDX_W-1:0] write_index, write_index_next;
  logic [brbf_pkg::CNT_W-1:0] fill_count, fill_count_next;

  // ram read stage and result register
  logic                 a_valid;
  logic                 a_use_ram;
  brbf_pkg::brbf_out_t  a_res, res_next;
  brbf_pkg::brbf_out_t  a_out;
  logic                 use_ram_next;
  logic                 a_adv;
  logic                 accept;

  // ram side
  logic                              ram_we;
  logic                              ram_re;
  logic [brbf_pkg::IDX_W-1:0]        ram_raddr;
  logic [brbf_pkg::DATA_W-1:0]       ram_rdata;

  logic [brbf_pkg::CNT_W-1:0] cap;
  logic [brbf_pkg::CNT_W-1:0] off_ext;
  logic [brbf_pkg::CNT_W-1:0] pop_n;

  assign cap     = brbf_pkg::eff_cap(capacity);
  assign off_ext = brbf_pkg::CNT_W'(req.peek_offset);
  assign pop_n   = (req.pop_count < fill_count) ? req.pop_count : fill_count;

  // second stage moves when the result register is free or being taken
  assign a_adv     = !rsp_valid || !rsp_stall;
  assign req_stall = a_valid && !a_adv;
  assign accept    = req_valid && !req_stall;

  // operation decode against the current state
  always_comb begin
    read_index_next  = read_index;
    write_index_next = write_index;
    fill_count_next  = fill_count;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_raddr        = read_index;
    use_ram_next     = 1'b0;
    res_next         = '0;

    unique case (brbf_pkg::kind_t'(req.kind))
      brbf_pkg::KIND_WRITE: begin
        if (fill_count < cap) begin
          ram_we              = accept;
          write_index_next    = brbf_pkg::wrap_add(write_index, brbf_pkg::CNT_W'(1), cap);
          fill_count_next     = fill_count + brbf_pkg::CNT_W'(1);
          res_next.done_res   = 1'b1;
          res_next.count_done = brbf_pkg::CNT_W'(1);
        end
      end
      brbf_pkg::KIND_READ: begin
        if (fill_count != '0) begin
          ram_re              = accept;
          use_ram_next        = 1'b1;
          read_index_next     = brbf_pkg::wrap_add(read_index, brbf_pkg::CNT_W'(1), cap);
          fill_count_next     = fill_count - brbf_pkg::CNT_W'(1);
          res_next.done_res   = 1'b1;
          res_next.count_done = brbf_pkg::CNT_W'(1);
        end
      end
      brbf_pkg::KIND_PEEK: begin
        if (off_ext < fill_count) begin
          ram_re              = accept;
          use_ram_next        = 1'b1;
          ram_raddr           = brbf_pkg::wrap_add(read_index, off_ext, cap);
          res_next.done_res   = 1'b1;
          res_next.count_done = off_ext + brbf_pkg::CNT_W'(1);
        end else begin
          res_next.count_done = fill_count;
        end
      end
      brbf_pkg::KIND_POP: begin
        read_index_next     = brbf_pkg::wrap_add(read_index, pop_n, cap);
        fill_count_next     = fill_count - pop_n;
        res_next.count_done = pop_n;
      end
      brbf_pkg::KIND_CLEAR: begin
        read_index_next     = write_index;
        fill_count_next     = '0;
        res_next.count_done = fill_count;
      end
      default: begin
        // unused kinds do nothing
      end
    endcase

    res_next.fill_level = fill_count_next;
    res_next.free_level = cap - fill_count_next;
  end

  brbf_ram #(
    .WIDTH (brbf_pkg::DATA_W),
    .DEPTH (brbf_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_index),
    .wdata (req.write_data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // capacity register and ring state; a capacity write empties the buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= brbf_pkg::CAP_RESET;
      read_index  <= '0;
      write_index <= '0;
      fill_count  <= '0;
    end else if (cfg_we) begin
      capacity    <= cfg_data;
      read_index  <= '0;
      write_index <= '0;
      fill_count  <= '0;
    end else if (accept) begin
      read_index  <= read_index_next;
      write_index <= write_index_next;
      fill_count  <= fill_count_next;
    end
  end

  // ram read stage; ram data holds while this stage holds
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_res     <= res_next;
      a_use_ram <= use_ram_next;
    end
  end

  // byte only for a read or peek that found data
  always_comb begin
    a_out           = a_res;
    a_out.read_data = a_use_ram ? ram_rdata : '0;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (a_valid && a_adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && a_adv) begin
      rsp <= a_out;
    end
  end

endmodule

// File: rtl/brbf_checker.sv
// brbf_checker: port-level assertions for byte_ring_buffer_fifo, bound to the top level
// depends on brbf_pkg
`timescale 1ns / 1ps

module brbf_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_stall,
  input logic                       rsp_valid,
  input logic                       rsp_stall,
  input brbf_pkg::brbf_out_t        rsp
);

  logic [brbf_pkg::CNT_W:0] level_sum;

  assign level_sum = (brbf_pkg::CNT_W+1)'(rsp.fill_level)
                   + (brbf_pkg::CNT_W+1)'(rsp.free_level);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // input only backs up when the result side is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("input stalled while result side free");

  // fill plus free is nonzero and no more than the storage depth
  a_levels: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> level_sum != '0
                  && level_sum <= (brbf_pkg::CNT_W+1)'(brbf_pkg::DEPTH))
    else $error("fill and free levels inconsistent");

  // no byte is returned without success
  a_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.done_res |-> rsp.read_data == '0)
    else $error("read data on failed operation");

endmodule

bind byte_ring_buffer_fifo brbf_checker u_brbf_checker (.*);
